@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in this cycle -> consequent holds in the same cycle
`define MFR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfr assertion failed");

// Antecedent holds in this cycle -> consequent holds in the next cycle
`define MFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfr assertion failed");

`endif

@@ src/mfr_pkg.sv @@
package mfr_pkg;

  localparam int POS_W          = 7;
  localparam int FRAME_OVERHEAD = 13;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 56;
  localparam int ADDR_BYTES     = 7;

  localparam logic [7:0] START_BYTE = 8'h68;
  localparam logic [7:0] END_BYTE   = 8'h16;
  localparam logic [7:0] BCAST_BYTE = 8'hAA;

  localparam logic [8:0] LEN_UNKNOWN = 9'h1FF;

  // byte counts after the current byte is taken
  localparam logic [POS_W-1:0] CNT_START = 7'd1;
  localparam logic [POS_W-1:0] CNT_TYPE  = 7'd2;
  localparam logic [POS_W-1:0] CNT_CTRL  = 7'd10;
  localparam logic [POS_W-1:0] CNT_LEN   = 7'd11;
  localparam logic [POS_W-1:0] CNT_HDR   = 7'd12;

  // frame offsets
  localparam int OFS_ADDR    = 2;
  localparam int OFS_PAYLOAD = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TYPE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b1;

  typedef enum logic [1:0] {
    KIND_STATUS       = 2'd0,
    KIND_PAYLOAD      = 2'd1,
    KIND_ADDR_REJECT  = 2'd2,
    KIND_CHECKSUM_ERR = 2'd3
  } kind_t;

endpackage

@@ src/mfr_frame_ram.sv @@
module mfr_frame_ram #(
  parameter int DEPTH = 61,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/meter_frame_receiver_unit.sv @@
// A byte that does not close a frame is taken and gives no result. A closing byte starts the
// address check, read back byte by byte from the frame store; after it the status item is loaded
// once the output is free, and payload bytes follow via ST_FETCH and ST_PAY (one RAM read each).
// The input is closed from the closing byte until the frame's last item is loaded; an output
// stall holds it closed longer. Reset (rst_n low, synchronous) clears the parser, the
// sequencer, out_tvalid and the configuration registers; the frame store is not cleared.
`include "assert_macros.svh"

module meter_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // [6:0] control_code,
                                                       // [12:7] payload_length,
                                                       // [20:13] payload_byte
  output logic [1:0]                       out_tuser,  // [1:0] kind
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [mfr_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [mfr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import mfr_pkg::*;

  localparam int DEPTH   = MAX_PAYLOAD + FRAME_OVERHEAD;
  localparam int AW      = $clog2(DEPTH);
  localparam int OVERRUN = MAX_PAYLOAD + FRAME_OVERHEAD - 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK,
    ST_STAT,
    ST_FETCH,
    ST_PAY
  } state_t;

  state_t                state_r;
  logic [POS_W-1:0]      pos_r;
  logic [POS_W-1:0]      pos_nxt;
  logic [POS_W-1:0]      cnt;
  logic [8:0]            exp_r;
  logic [8:0]            exp_nxt;
  logic                  frame_done;
  logic                  in_fire;
  logic [7:0]            sum_all_r;
  logic [7:0]            sum_prev_r;
  logic [7:0]            prev_byte_r;
  logic [7:0]            sum_base;
  logic [6:0]            ctrl_r;
  logic [5:0]            len_r;
  logic                  chk_ok_r;
  logic                  addr_ok_r;
  logic                  own_r;
  logic                  bcast_r;
  logic [2:0]            step_r;
  logic [2:0]            cmp_idx;
  logic [7:0]            addr_byte;
  logic                  own_hit;
  logic                  bcast_hit;
  logic [AW-1:0]         ra_r;
  logic [5:0]            pay_cnt_r;
  logic                  pay_last;
  logic [7:0]            rd_data;
  logic                  store_we;
  logic [7:0]            dev_type_r;
  logic [CFG_DATA_W-1:0] dev_addr_r;
  logic                  out_free;
  logic                  out_load;
  logic                  frame_bad;
  logic                  out_tvalid_r;
  logic                  out_tlast_r;
  kind_t                 out_kind_r;
  logic [7:0]            out_byte_r;
  logic [6:0]            out_ctrl_r;
  logic [5:0]            out_len_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cnt       = pos_r + POS_W'(1);
  assign store_we  = in_fire && (pos_r < POS_W'(DEPTH));
  assign sum_base  = (pos_r == '0) ? 8'd0 : sum_all_r;

  always_comb begin
    pos_nxt    = cnt;
    exp_nxt    = exp_r;
    frame_done = 1'b0;
    if (cnt > CNT_HDR) begin
      if (in_tdata == END_BYTE && {2'b00, cnt} == exp_r) begin
        frame_done = 1'b1;
        pos_nxt    = '0;
        exp_nxt    = LEN_UNKNOWN;
      end else if ({2'b00, cnt} > exp_r || cnt >= POS_W'(OVERRUN)) begin
        pos_nxt = '0;
        exp_nxt = LEN_UNKNOWN;
      end
    end else begin
      case (cnt)
        CNT_LEN:   exp_nxt = 9'(in_tdata) + 9'(FRAME_OVERHEAD);
        CNT_CTRL:  if (in_tdata[7]) pos_nxt = '0;
        CNT_TYPE:  if (in_tdata != dev_type_r) pos_nxt = '0;
        CNT_START: if (in_tdata != START_BYTE) pos_nxt = '0;
        default:   ;
      endcase
    end
  end

  mfr_frame_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (pos_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (ra_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_type_r <= '0;
      dev_addr_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEVICE_TYPE:    dev_type_r <= cfg_wdata[7:0];
        CFG_DEVICE_ADDRESS: dev_addr_r <= cfg_wdata;
        default:            ;
      endcase
    end
  end

  // header parsing and running checksum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      exp_r <= LEN_UNKNOWN;
    end else if (in_fire) begin
      pos_r <= pos_nxt;
      exp_r <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sum_prev_r  <= sum_base;
      sum_all_r   <= sum_base + in_tdata;
      prev_byte_r <= in_tdata;
      if (cnt == CNT_CTRL) ctrl_r <= in_tdata[6:0];
      if (cnt == CNT_LEN) len_r <= in_tdata[5:0];
      if (frame_done) chk_ok_r <= (sum_prev_r == prev_byte_r);
    end
  end

  // address byte compared against the RAM word addressed in the previous cycle
  assign cmp_idx   = step_r - 3'd1;
  assign addr_byte = dev_addr_r[{cmp_idx, 3'b000} +: 8];
  assign own_hit   = (rd_data == addr_byte);
  assign bcast_hit = (rd_data == BCAST_BYTE);
  assign out_free  = !out_tvalid_r || out_tready;
  assign out_load  = out_free && (state_r == ST_STAT || state_r == ST_PAY);
  assign frame_bad = !addr_ok_r || !chk_ok_r;
  assign pay_last  = ({1'b0, pay_cnt_r} + 7'd1) == {1'b0, len_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && frame_done) begin
            ra_r    <= AW'(OFS_ADDR);
            step_r  <= '0;
            state_r <= ST_CHK;
          end
        end
        ST_CHK: begin
          ra_r   <= ra_r + AW'(1);
          step_r <= step_r + 3'd1;
          if (step_r == 3'd1) begin
            own_r   <= own_hit;
            bcast_r <= bcast_hit;
          end else if (step_r != 3'd0) begin
            own_r   <= own_r && own_hit;
            bcast_r <= bcast_r && bcast_hit;
          end
          if (step_r == 3'(ADDR_BYTES)) begin
            addr_ok_r <= (own_r && own_hit) || (bcast_r && bcast_hit);
            state_r   <= ST_STAT;
          end
        end
        ST_STAT: begin
          if (out_free) begin
            out_ctrl_r   <= ctrl_r;
            out_len_r    <= len_r;
            out_byte_r   <= 8'd0;
            out_tlast_r  <= frame_bad || (len_r == '0);
            if (!addr_ok_r) begin
              out_kind_r <= KIND_ADDR_REJECT;
            end else if (!chk_ok_r) begin
              out_kind_r <= KIND_CHECKSUM_ERR;
            end else begin
              out_kind_r <= KIND_STATUS;
            end
            if (frame_bad || len_r == '0) begin
              state_r <= ST_IDLE;
            end else begin
              ra_r      <= AW'(OFS_PAYLOAD);
              pay_cnt_r <= '0;
              state_r   <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          state_r <= ST_PAY;
        end
        ST_PAY: begin
          if (out_free) begin
            out_kind_r   <= KIND_PAYLOAD;
            out_ctrl_r   <= ctrl_r;
            out_len_r    <= len_r;
            out_byte_r   <= rd_data;
            out_tlast_r  <= pay_last;
            pay_cnt_r    <= pay_cnt_r + 6'd1;
            ra_r         <= ra_r + AW'(1);
            state_r      <= pay_last ? ST_IDLE : ST_FETCH;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_byte_r, out_len_r, out_ctrl_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_tlast_r;

  `MFR_ASSERT_NEXT(a_done_starts_check, clk, rst_n, in_fire && frame_done, state_r == ST_CHK)
  `MFR_ASSERT_IMPL(a_pos_below_overrun, clk, rst_n, 1'b1, pos_r < POS_W'(OVERRUN))
  `MFR_ASSERT_IMPL(a_pay_in_range, clk, rst_n, state_r == ST_FETCH || state_r == ST_PAY, pay_cnt_r < len_r)

endmodule
